// ===== src/qtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qtrs_pkg
// Shared widths, types and rounding helper for the TRS model-matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qtrs_pkg;

    localparam int QUAT_W     = 16;
    localparam int SCALE_W    = 24;
    localparam int POS_W      = 32;
    localparam int OUT_W      = 32;
    localparam int PPROD_W    = 2 * QUAT_W;
    localparam int ENTRY_W    = PPROD_W + 3;
    localparam int PROD_W     = ENTRY_W + SCALE_W;
    localparam int FRAC_SHIFT = 30;
    localparam int QUOT_W     = PROD_W - FRAC_SHIFT;
    localparam int NUM_ENT    = 9;
    localparam int NUM_ROW    = 3;
    localparam int NUM_STAGE  = 4;

    typedef logic signed [QUAT_W-1:0]  quat_t;
    typedef logic signed [SCALE_W-1:0] scale_t;
    typedef logic signed [POS_W-1:0]   pos_t;
    typedef logic signed [OUT_W-1:0]   out_t;
    typedef logic signed [PPROD_W-1:0] pprod_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [PROD_W-1:0]  prod_t;

    typedef entry_t entry_arr_t [NUM_ENT];
    typedef scale_t scale_arr_t [NUM_ROW];
    typedef out_t   out_arr_t   [NUM_ENT];
    typedef pos_t   pos_arr_t   [NUM_ROW];

    typedef struct packed {
        logic load_a;
        logic load_b;
    } stage_en_t;

    localparam entry_t ONE_Q30 = entry_t'(1) <<< FRAC_SHIFT;
    localparam logic signed [63:0] OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [63:0] OUT_MIN = -(64'sd1 <<< (OUT_W - 1));

    // round half up at bit FRAC_SHIFT, then clamp to the output range
    function automatic out_t round_sat(input prod_t p);
        prod_t                    r;
        logic signed [QUOT_W-1:0] q;
        logic signed [63:0]       qx;
        r  = p + (prod_t'(1) <<< (FRAC_SHIFT - 1));
        q  = r[PROD_W-1:FRAC_SHIFT];
        qx = 64'(q);
        if (qx > OUT_MAX)
        begin
            qx = OUT_MAX;
        end
        else if (qx < OUT_MIN)
        begin
            qx = OUT_MIN;
        end
        return OUT_W'(qx);
    endfunction

endpackage

`default_nettype wire

// ===== src/qtrs_quat_prod.sv =====
// ----------------------------------------------------------------------------
// qtrs_quat_prod
// Quaternion component products (stage 1) and rotation entries in Q.30
// (stage 2). Scales travel alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module qtrs_quat_prod
(
    input  wire                     clk,
    input  qtrs_pkg::stage_en_t     ctl,
    input  qtrs_pkg::quat_t         quat_x,
    input  qtrs_pkg::quat_t         quat_y,
    input  qtrs_pkg::quat_t         quat_z,
    input  qtrs_pkg::quat_t         quat_w,
    input  qtrs_pkg::scale_arr_t    scale_in,
    output qtrs_pkg::entry_arr_t    entry,
    output qtrs_pkg::scale_arr_t    scale_out
);
    import qtrs_pkg::*;

    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    pprod_t     prod_reg  [NUM_ENT];
    pprod_t     prod_next [NUM_ENT];
    scale_arr_t scale_s1_reg;
    entry_arr_t entry_reg;
    entry_arr_t entry_next;
    scale_arr_t scale_s2_reg;
    entry_t     ep        [NUM_ENT];

    always_comb
    begin
        prod_next[P_XX] = PPROD_W'(quat_x) * PPROD_W'(quat_x);
        prod_next[P_YY] = PPROD_W'(quat_y) * PPROD_W'(quat_y);
        prod_next[P_ZZ] = PPROD_W'(quat_z) * PPROD_W'(quat_z);
        prod_next[P_XY] = PPROD_W'(quat_x) * PPROD_W'(quat_y);
        prod_next[P_XZ] = PPROD_W'(quat_x) * PPROD_W'(quat_z);
        prod_next[P_YZ] = PPROD_W'(quat_y) * PPROD_W'(quat_z);
        prod_next[P_WX] = PPROD_W'(quat_w) * PPROD_W'(quat_x);
        prod_next[P_WY] = PPROD_W'(quat_w) * PPROD_W'(quat_y);
        prod_next[P_WZ] = PPROD_W'(quat_w) * PPROD_W'(quat_z);
    end

    always_comb
    begin
        for (int i = 0; i < NUM_ENT; i++)
        begin
            ep[i] = ENTRY_W'(prod_reg[i]);
        end
        entry_next[0] = ONE_Q30 - ((ep[P_YY] + ep[P_ZZ]) <<< 1);
        entry_next[1] = (ep[P_XY] + ep[P_WZ]) <<< 1;
        entry_next[2] = (ep[P_XZ] - ep[P_WY]) <<< 1;
        entry_next[3] = (ep[P_XY] - ep[P_WZ]) <<< 1;
        entry_next[4] = ONE_Q30 - ((ep[P_XX] + ep[P_ZZ]) <<< 1);
        entry_next[5] = (ep[P_YZ] + ep[P_WX]) <<< 1;
        entry_next[6] = (ep[P_XZ] + ep[P_WY]) <<< 1;
        entry_next[7] = (ep[P_YZ] - ep[P_WX]) <<< 1;
        entry_next[8] = ONE_Q30 - ((ep[P_XX] + ep[P_YY]) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            prod_reg     <= prod_next;
            scale_s1_reg <= scale_in;
        end
        if (ctl.load_b)
        begin
            entry_reg    <= entry_next;
            scale_s2_reg <= scale_s1_reg;
        end
    end

    assign entry     = entry_reg;
    assign scale_out = scale_s2_reg;

endmodule

`default_nettype wire

// ===== src/qtrs_scale_round.sv =====
// ----------------------------------------------------------------------------
// qtrs_scale_round
// Row scaling multiply (stage 3) and round / saturate to Q16.16 (stage 4).
// ----------------------------------------------------------------------------
`default_nettype none

module qtrs_scale_round
(
    input  wire                     clk,
    input  qtrs_pkg::stage_en_t     ctl,
    input  qtrs_pkg::entry_arr_t    entry,
    input  qtrs_pkg::scale_arr_t    scale,
    output qtrs_pkg::out_arr_t      result
);
    import qtrs_pkg::*;

    prod_t    prod_reg  [NUM_ENT];
    prod_t    prod_next [NUM_ENT];
    out_arr_t res_reg;
    out_arr_t res_next;

    always_comb
    begin
        for (int i = 0; i < NUM_ENT; i++)
        begin
            prod_next[i] = PROD_W'(entry[i]) * PROD_W'(scale[i / NUM_ROW]);
            res_next[i]  = round_sat(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_a)
        begin
            prod_reg <= prod_next;
        end
        if (ctl.load_b)
        begin
            res_reg <= res_next;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// ===== src/quaternion_trs_matrix.sv =====
// ----------------------------------------------------------------------------
// quaternion_trs_matrix
// Quaternion + scale + position to the rows of a row-major 4x4 model matrix.
// ----------------------------------------------------------------------------
// Accepts one transform per clock unless in_stall is high and returns its nine
// rotation-scale entries and translation from the last stage. The four
// register stages are: 16x16 quaternion products, Q.30 entry sums, the
// 35x24 row-scale multipliers, and round-half-up / saturate into the output
// register. An output stall only holds stages that are full, so bubbles
// collapse and the input keeps taking transactions until the pipe is full.
`default_nettype none

module quaternion_trs_matrix
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     in_valid,
    output logic                    in_stall,
    input  qtrs_pkg::pos_t          pos_x,
    input  qtrs_pkg::pos_t          pos_y,
    input  qtrs_pkg::pos_t          pos_z,
    input  qtrs_pkg::quat_t         quat_x,
    input  qtrs_pkg::quat_t         quat_y,
    input  qtrs_pkg::quat_t         quat_z,
    input  qtrs_pkg::quat_t         quat_w,
    input  qtrs_pkg::scale_t        scale_x,
    input  qtrs_pkg::scale_t        scale_y,
    input  qtrs_pkg::scale_t        scale_z,
    output logic                    out_valid,
    input  wire                     out_stall,
    output qtrs_pkg::out_t          r00,
    output qtrs_pkg::out_t          r01,
    output qtrs_pkg::out_t          r02,
    output qtrs_pkg::out_t          r10,
    output qtrs_pkg::out_t          r11,
    output qtrs_pkg::out_t          r12,
    output qtrs_pkg::out_t          r20,
    output qtrs_pkg::out_t          r21,
    output qtrs_pkg::out_t          r22,
    output qtrs_pkg::pos_t          trans_x,
    output qtrs_pkg::pos_t          trans_y,
    output qtrs_pkg::pos_t          trans_z
);
    import qtrs_pkg::*;

    logic [NUM_STAGE-1:0] valid_reg;
    logic [NUM_STAGE-1:0] valid_next;
    logic [NUM_STAGE-1:0] stage_en;
    pos_arr_t             pos_reg  [NUM_STAGE];
    pos_arr_t             pos_next [NUM_STAGE];
    scale_arr_t           scale_in;
    scale_arr_t           scale_mid;
    entry_arr_t           entry;
    out_arr_t             result;
    stage_en_t            prod_ctl;
    stage_en_t            scale_ctl;

    // a stage loads when it is empty or its successor loads
    always_comb
    begin
        stage_en[NUM_STAGE-1] = !valid_reg[NUM_STAGE-1] || !out_stall;
        for (int k = NUM_STAGE - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = in_valid;
        pos_next[0]   = '{pos_x, pos_y, pos_z};
        for (int k = 1; k < NUM_STAGE; k++)
        begin
            valid_next[k] = valid_reg[k-1];
            pos_next[k]   = pos_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGE; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGE; k++)
        begin
            if (stage_en[k])
            begin
                pos_reg[k] <= pos_next[k];
            end
        end
    end

    assign scale_in  = '{scale_x, scale_y, scale_z};
    assign prod_ctl  = '{load_a: stage_en[0], load_b: stage_en[1]};
    assign scale_ctl = '{load_a: stage_en[2], load_b: stage_en[3]};

    qtrs_quat_prod u_quat_prod
    (
        .clk       (clk),
        .ctl       (prod_ctl),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .scale_in  (scale_in),
        .entry     (entry),
        .scale_out (scale_mid)
    );

    qtrs_scale_round u_scale_round
    (
        .clk    (clk),
        .ctl    (scale_ctl),
        .entry  (entry),
        .scale  (scale_mid),
        .result (result)
    );

    assign in_stall  = !stage_en[0];
    assign out_valid = valid_reg[NUM_STAGE-1];
    assign r00       = result[0];
    assign r01       = result[1];
    assign r02       = result[2];
    assign r10       = result[3];
    assign r11       = result[4];
    assign r12       = result[5];
    assign r20       = result[6];
    assign r21       = result[7];
    assign r22       = result[8];
    assign trans_x   = pos_reg[NUM_STAGE-1][0];
    assign trans_y   = pos_reg[NUM_STAGE-1][1];
    assign trans_z   = pos_reg[NUM_STAGE-1][2];

    a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled while output drains");

    a_full_pipe_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall && valid_reg[0] && valid_reg[1] && valid_reg[2])
        |-> in_stall)
        else $error("full pipeline took a transaction under output stall");

    a_bubble_only_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (in_stall) |-> (out_valid && out_stall))
        else $error("input stalled with room in the pipeline");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
        else $error("transaction did not reach output after four stages");

endmodule

`default_nettype wire
